// ===== rtl/rilp_pkg.sv =====
// ----------------------------------------------------------------------------
// rilp_pkg
// Shared types, character codes and digit helpers for the literal parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rilp_pkg;

	// longest literal in bytes; the byte counter saturates here
	localparam logic [7:0] MAX_LENGTH = 8'd150;

	// parse phases
	localparam logic [2:0] PH_SIGN   = 3'd0;
	localparam logic [2:0] PH_FIRST  = 3'd1;
	localparam logic [2:0] PH_HOLD1  = 3'd2;
	localparam logic [2:0] PH_HOLD2  = 3'd3;
	localparam logic [2:0] PH_ZEROS  = 3'd4;
	localparam logic [2:0] PH_DIGITS = 3'd5;

	// character codes
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;

	localparam logic [7:0] NO_DIGIT    = 8'hFF;
	localparam logic [7:0] ALPHA_FIRST = 8'd10;

	localparam logic [5:0] RADIX_DEC = 6'd10;
	localparam logic [5:0] RADIX_HEX = 6'd16;
	localparam logic [6:0] RADIX_MIN = 7'd2;
	localparam logic [6:0] RADIX_MAX = 7'd36;

	// magnitude of the most negative int64
	localparam logic [63:0] INT64_MIN_MAG = 64'h8000_0000_0000_0000;

	// per-literal parse state
	typedef struct packed {
		logic [63:0] acc;
		logic [5:0]  radix;
		logic        neg;
		logic        seen;
		logic        failed;
		logic [2:0]  phase;
		logic [7:0]  count;
	} rilp_state_t;

	localparam rilp_state_t STATE_RESET = '{
		acc:    64'd0,
		radix:  RADIX_DEC,
		neg:    1'b0,
		seen:   1'b0,
		failed: 1'b0,
		phase:  PH_SIGN,
		count:  8'd0
	};

	typedef struct packed {
		logic        ok;
		logic [63:0] value;
	} rilp_result_t;

	// narrow base-ten accumulator for replaying held prefix bytes (at most 3 digits)
	typedef struct packed {
		logic [9:0] acc;
		logic       seen;
		logic       failed;
		logic       digits;
	} rilp_small_t;

	localparam rilp_small_t SMALL_FRESH = '{acc: 10'd0, seen: 1'b0, failed: 1'b0, digits: 1'b0};

	function automatic logic is_dec(input logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

	function automatic logic [7:0] digit_of(input logic [7:0] b);
		logic [7:0] d;
		if (is_dec(b)) begin
			d = b - CH_ZERO;
		end else if ((b >= CH_LA) && (b <= CH_LZ)) begin
			d = b - CH_LA + ALPHA_FIRST;
		end else if ((b >= CH_UA) && (b <= CH_UZ)) begin
			d = b - CH_UA + ALPHA_FIRST;
		end else begin
			d = NO_DIGIT;
		end
		return d;
	endfunction

	// one base-ten digit step on the narrow accumulator
	function automatic rilp_small_t feed10(input rilp_small_t s, input logic [7:0] b);
		rilp_small_t r;
		logic [7:0]  d;
		r = s;
		d = digit_of(b);
		if (!r.failed) begin
			if (!r.digits && (b == CH_ZERO)) begin
				r.seen = 1'b1;
			end else begin
				r.digits = 1'b1;
				if (b == CH_UNDER) begin
					if (!r.seen) r.failed = 1'b1;
				end else if (d >= {2'b00, RADIX_DEC}) begin
					r.failed = 1'b1;
				end else begin
					r.acc  = 10'(r.acc * 10'(RADIX_DEC)) + {6'b000000, d[3:0]};
					r.seen = 1'b1;
				end
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/rilp_if.sv =====
// ----------------------------------------------------------------------------
// rilp_if
// Valid/ready channels of the literal parser: bytes in, results out, config.
// ----------------------------------------------------------------------------
`default_nettype none

interface rilp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       last_byte;

	modport source (output valid, output byte_value, output last_byte, input ready);
	modport sink (input valid, input byte_value, input last_byte, output ready);
endinterface

interface rilp_result_if;
	logic        valid;
	logic        ready;
	logic        ok;
	logic [63:0] value;

	modport source (output valid, output ok, output value, input ready);
	modport sink (input valid, input ok, input value, output ready);
endinterface

interface rilp_cfg_if;
	logic valid;
	logic ready;
	logic signed_result;

	modport source (output valid, output signed_result, input ready);
	modport sink (input valid, input signed_result, output ready);
endinterface

`default_nettype wire

// ===== rtl/rilp_step.sv =====
// ----------------------------------------------------------------------------
// rilp_step
// Next-state and result logic for one literal byte.
// ----------------------------------------------------------------------------
`default_nettype none

module rilp_step (
	input  rilp_pkg::rilp_state_t  cur,
	input  logic [7:0]             hold0,
	input  logic [7:0]             hold1,
	input  logic [7:0]             byte_value,
	input  logic                   last_byte,
	input  logic                   signed_mode,
	output rilp_pkg::rilp_state_t  nxt,
	output logic [7:0]             hold0_nxt,
	output logic [7:0]             hold1_nxt,
	output rilp_pkg::rilp_result_t res
);
	import rilp_pkg::*;

	rilp_state_t s;
	rilp_small_t sm_h1;
	rilp_small_t sm_h2;
	rilp_small_t sm_f1;
	rilp_small_t sm_f2;
	logic [7:0]  d;
	logic [69:0] mac;
	logic [6:0]  base2;
	logic        fits;

	// load the state from a replay of held bytes in base ten
	function automatic rilp_state_t from_small(input rilp_state_t st, input rilp_small_t sm);
		rilp_state_t r;
		r        = st;
		r.acc    = 64'(sm.acc);
		r.seen   = sm.seen;
		r.failed = sm.failed;
		r.radix  = RADIX_DEC;
		r.phase  = sm.digits ? PH_DIGITS : PH_ZEROS;
		return r;
	endfunction

	always_comb begin
		s         = cur;
		hold0_nxt = hold0;
		hold1_nxt = hold1;
		d         = digit_of(byte_value);
		// exact product; bits above 63 mean overflow
		mac       = 70'(cur.acc) * 70'(cur.radix) + 70'(d);
		base2     = 7'(7'(hold0[3:0]) * 7'(RADIX_DEC)) + 7'(hold1[3:0]);
		sm_h1     = feed10(feed10(SMALL_FRESH, hold0), byte_value);
		sm_h2     = feed10(feed10(feed10(SMALL_FRESH, hold0), hold1), byte_value);

		if (cur.count >= MAX_LENGTH) begin
			s.failed = 1'b1;
		end else begin
			s.count = cur.count + 8'd1;
		end

		if (!s.failed) begin
			case (cur.phase)
				PH_SIGN: begin
					if (byte_value == CH_MINUS) begin
						s.neg   = 1'b1;
						s.phase = PH_FIRST;
					end else if (byte_value == CH_PLUS) begin
						s.phase = PH_FIRST;
					end else begin
						hold0_nxt = byte_value;
						s.phase   = PH_HOLD1;
					end
				end
				PH_FIRST: begin
					hold0_nxt = byte_value;
					s.phase   = PH_HOLD1;
				end
				PH_HOLD1: begin
					hold1_nxt = byte_value;
					if ((hold0 == CH_ZERO) && (byte_value == CH_X)) begin
						s.radix = RADIX_HEX;
						s.phase = PH_ZEROS;
					end else if (is_dec(hold0) && (byte_value == CH_R)) begin
						s.radix = 6'(hold0[3:0]);
						s.phase = PH_ZEROS;
					end else if (is_dec(hold0) && is_dec(byte_value)) begin
						s.phase = PH_HOLD2;
					end else begin
						s = from_small(s, sm_h1);
					end
				end
				PH_HOLD2: begin
					if (byte_value == CH_R) begin
						if ((base2 < RADIX_MIN) || (base2 > RADIX_MAX)) begin
							s.failed = 1'b1;
						end else begin
							s.radix = base2[5:0];
							s.phase = PH_ZEROS;
						end
					end else begin
						s = from_small(s, sm_h2);
					end
				end
				default: begin
					if ((cur.phase == PH_ZEROS) && (byte_value == CH_ZERO)) begin
						s.seen = 1'b1;
					end else begin
						s.phase = PH_DIGITS;
						if (byte_value == CH_UNDER) begin
							if (!cur.seen) s.failed = 1'b1;
						end else if (d >= {2'b00, cur.radix}) begin
							s.failed = 1'b1;
						end else if (mac[69:64] != 6'd0) begin
							s.failed = 1'b1;
						end else begin
							s.acc  = mac[63:0];
							s.seen = 1'b1;
						end
					end
				end
			endcase
		end

		// literal ended while prefix bytes were still held
		sm_f1 = feed10(SMALL_FRESH, hold0_nxt);
		sm_f2 = feed10(sm_f1, hold1_nxt);
		if (last_byte && !s.failed) begin
			if (s.phase == PH_HOLD1) begin
				s = from_small(s, sm_f1);
			end else if (s.phase == PH_HOLD2) begin
				s = from_small(s, sm_f2);
			end
		end

		if (signed_mode) begin
			fits = s.neg ? (!s.acc[63] || (s.acc == INT64_MIN_MAG)) : !s.acc[63];
		end else begin
			fits = !s.neg;
		end
		res.ok    = !s.failed && s.seen && fits;
		res.value = res.ok ? (s.neg ? (~s.acc + 64'd1) : s.acc) : 64'd0;

		nxt = last_byte ? STATE_RESET : s;
	end

endmodule

`default_nettype wire

// ===== rtl/radix_integer_literal_parser.sv =====
// ----------------------------------------------------------------------------
// radix_integer_literal_parser
// Pipeline: a word is registered in the input stage at acceptance; a last
//   byte's result is registered in the result register when it advances.
// Throughput: one byte per cycle unless a last byte waits for a result slot;
//   bounded by the step logic's 64x6 bit multiply-add and overflow check.
// Reset: asynchronous, active low; clears parse state, mode and valids.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_integer_literal_parser (
	input logic           clk,
	input logic           arst_n,
	rilp_byte_if.sink     literal,
	rilp_result_if.source result,
	rilp_cfg_if.sink      cfg
);
	import rilp_pkg::*;

	// input stage
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	// parse state, and prefix lookahead bytes that have no reset (written before read)
	rilp_state_t state_q;
	rilp_state_t state_nxt;
	logic [7:0]  hold0_q;
	logic [7:0]  hold1_q;
	logic [7:0]  hold0_nxt;
	logic [7:0]  hold1_nxt;

	logic        signed_q;

	// result register
	rilp_result_t res_nxt;
	logic         out_valid_q;
	logic         ok_q;
	logic [63:0]  value_q;

	logic advance;
	logic in_take;

	// a byte without last never blocks; a last byte waits for a free result slot
	assign advance       = valid_s1 && (!last_s1 || !out_valid_q || result.ready);
	assign literal.ready = !valid_s1 || advance;
	assign in_take       = literal.valid && literal.ready;

	// mode register is always writable
	assign cfg.ready = 1'b1;

	assign result.valid = out_valid_q;
	assign result.ok    = ok_q;
	assign result.value = value_q;

	rilp_step u_step (
		.cur        (state_q),
		.hold0      (hold0_q),
		.hold1      (hold1_q),
		.byte_value (byte_s1),
		.last_byte  (last_s1),
		.signed_mode(signed_q),
		.nxt        (state_nxt),
		.hold0_nxt  (hold0_nxt),
		.hold1_nxt  (hold1_nxt),
		.res        (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= literal.byte_value;
			last_s1 <= literal.last_byte;
		end
	end

	// parse state returns to reset after every last byte (done in step logic)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hold0_q <= hold0_nxt;
			hold1_q <= hold1_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_q <= 1'b0;
		end else if (cfg.valid) begin
			signed_q <= cfg.signed_result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			ok_q    <= res_nxt.ok;
			value_q <= res_nxt.value;
		end
	end

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for radix_integer_literal_parser. Feeds literal text one byte per
// word through the valid/ready input channel, predicts each parse result with
// a behavioral model kept in step with every accepted word, and checks every
// result word in order. Directed literals cover signs, prefixes, bases, digit
// cases, overflow edges and the length limit, in both result modes. Random
// literals follow, mostly well formed, with noise mixed in. Both sides idle at
// random, and one long output hold-off forces the parser to stall its input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rilp_pkg::*;

	logic clk;
	logic arst_n;

	rilp_byte_if   lit_if ();
	rilp_result_if res_if ();
	rilp_cfg_if    cfg_if ();

	radix_integer_literal_parser dut (
		.clk    (clk),
		.arst_n (arst_n),
		.literal(lit_if),
		.result (res_if),
		.cfg    (cfg_if)
	);

	// parse results still owed by the parser, oldest first
	rilp_result_t literal_results[$];

	int mismatches;
	int bytes_sent;
	bit idle_on;        // random gaps on both channels
	int hold_request;   // cycles of output hold-off, picked up by the sink

	// ------------------------------------------------------------------------
	// Behavioral model of the parser state
	// ------------------------------------------------------------------------
	logic [63:0] lit_acc;
	logic [5:0]  lit_radix;
	logic        lit_neg;
	logic        lit_seen;
	logic        lit_bad;
	logic [2:0]  lit_phase;
	logic [7:0]  lit_hold [3];
	logic [7:0]  lit_len;
	logic        mode_signed;

	function automatic void reset_literal_model();
		lit_acc   = '0;
		lit_radix = RADIX_DEC;
		lit_neg   = 1'b0;
		lit_seen  = 1'b0;
		lit_bad   = 1'b0;
		lit_phase = PH_SIGN;
		lit_hold[0] = '0;
		lit_hold[1] = '0;
		lit_hold[2] = '0;
		lit_len   = '0;
	endfunction

	function automatic logic is_decimal(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// value 0..35 of a digit character, all ones when it is no digit
	function automatic logic [7:0] char_value(input logic [7:0] c);
		if ((c >= CH_ZERO) && (c <= CH_NINE)) return c - CH_ZERO;
		if ((c >= CH_LA) && (c <= CH_LZ)) return c - CH_LA + 8'd10;
		if ((c >= CH_UA) && (c <= CH_UZ)) return c - CH_UA + 8'd10;
		return 8'hFF;
	endfunction

	function automatic void begin_digits(input logic [5:0] b);
		lit_radix = b;
		lit_phase = PH_ZEROS;
	endfunction

	// one byte of the digit part, after any prefix
	function automatic void accumulate_char(input logic [7:0] c);
		logic [7:0]  d;
		logic [63:0] limit;
		if (lit_bad) return;
		if (lit_phase == PH_ZEROS) begin
			if (c == CH_ZERO) begin
				lit_seen = 1'b1;
				return;
			end
			lit_phase = PH_DIGITS;
		end
		if (c == CH_UNDER) begin
			if (!lit_seen) lit_bad = 1'b1;
			return;
		end
		d = char_value(c);
		if ((c > 8'd127) || (d >= {2'b00, lit_radix}) || (lit_radix == 6'd0)) begin
			lit_bad = 1'b1;
			return;
		end
		limit = (64'hFFFF_FFFF_FFFF_FFFF - {56'd0, d}) / {58'd0, lit_radix};
		if (lit_acc > limit) begin
			lit_bad = 1'b1;
			return;
		end
		lit_acc  = lit_acc * {58'd0, lit_radix} + {56'd0, d};
		lit_seen = 1'b1;
	endfunction

	// sign and prefix recognition; bytes are held until the prefix is known
	function automatic void advance_prefix(input logic [7:0] c);
		int b;
		if (lit_bad) return;
		case (lit_phase)
			PH_SIGN: begin
				lit_phase = PH_FIRST;
				if (c == CH_MINUS) begin
					lit_neg = 1'b1;
				end else if (c != CH_PLUS) begin
					lit_hold[0] = c;
					lit_phase = PH_HOLD1;
				end
			end
			PH_FIRST: begin
				lit_hold[0] = c;
				lit_phase = PH_HOLD1;
			end
			PH_HOLD1: begin
				lit_hold[1] = c;
				if ((lit_hold[0] == CH_ZERO) && (c == CH_X)) begin
					begin_digits(RADIX_HEX);
				end else if (is_decimal(lit_hold[0]) && (c == CH_R)) begin
					begin_digits(6'(lit_hold[0] - CH_ZERO));
				end else if (is_decimal(lit_hold[0]) && is_decimal(c)) begin
					lit_phase = PH_HOLD2;
				end else begin
					begin_digits(RADIX_DEC);
					accumulate_char(lit_hold[0]);
					accumulate_char(c);
				end
			end
			PH_HOLD2: begin
				lit_hold[2] = c;
				if (c == CH_R) begin
					b = 10 * int'(lit_hold[0] - CH_ZERO) + int'(lit_hold[1] - CH_ZERO);
					if ((b < 2) || (b > 36)) lit_bad = 1'b1;
					else begin_digits(6'(b));
				end else begin
					begin_digits(RADIX_DEC);
					accumulate_char(lit_hold[0]);
					accumulate_char(lit_hold[1]);
					accumulate_char(c);
				end
			end
			default: begin
				accumulate_char(c);
			end
		endcase
	endfunction

	// model step for one accepted word; a last byte queues one result
	function automatic void parse_byte(input logic [7:0] c, input logic last);
		rilp_result_t r;
		if (lit_len >= MAX_LENGTH) lit_bad = 1'b1;
		else lit_len = lit_len + 8'd1;
		advance_prefix(c);
		if (!last) return;
		// a literal ending inside the prefix lookahead is plain decimal
		if (!lit_bad && (lit_phase == PH_HOLD1)) begin
			begin_digits(RADIX_DEC);
			accumulate_char(lit_hold[0]);
		end else if (!lit_bad && (lit_phase == PH_HOLD2)) begin
			begin_digits(RADIX_DEC);
			accumulate_char(lit_hold[0]);
			accumulate_char(lit_hold[1]);
		end
		r = '0;
		if (!lit_bad && lit_seen) begin
			if (mode_signed) begin
				if (lit_neg && (lit_acc <= INT64_MIN_MAG)) begin
					r.ok = 1'b1;
					r.value = ~lit_acc + 64'd1;
				end else if (!lit_neg && (lit_acc < INT64_MIN_MAG)) begin
					r.ok = 1'b1;
					r.value = lit_acc;
				end
			end else if (!lit_neg) begin
				r.ok = 1'b1;
				r.value = lit_acc;
			end
		end
		literal_results.push_back(r);
		reset_literal_model();
	endfunction

	// ------------------------------------------------------------------------
	// Clock, reset and watchdog
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// slowest correct run is well under 1 ms; this allows several times that
	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Result sink: checks each accepted result word against the oldest
	// prediction, then draws its stall for the next word. A hold-off request
	// from a test keeps ready low for that many cycles, counted here.
	// ------------------------------------------------------------------------
	initial begin
		int stall_left;
		int hold_left;
		rilp_result_t want;
		stall_left = 0;
		hold_left = 0;
		res_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (res_if.valid && res_if.ready) begin
				if (literal_results.size() == 0) begin
					$error("result word with no literal pending: ok=%0d value=%h",
						res_if.ok, res_if.value);
					mismatches++;
				end else begin
					want = literal_results.pop_front();
					if (res_if.ok !== want.ok) begin
						$error("ok: expected %0d, got %0d", want.ok, res_if.ok);
						mismatches++;
					end
					if (res_if.value !== want.value) begin
						$error("value: expected %h, got %h", want.value, res_if.value);
						mismatches++;
					end
				end
				stall_left = idle_on ? $urandom_range(0, 9) : 0;
			end
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Byte source
	// ------------------------------------------------------------------------

	// Offer one word after a random gap and hold it until accepted. Called
	// right after the clock rises; returns right after the word is accepted.
	task automatic send_byte(input logic [7:0] c, input logic last);
		int gap;
		gap = idle_on ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			lit_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		lit_if.valid      <= 1'b1;
		lit_if.byte_value <= c;
		lit_if.last_byte  <= last;
		@(posedge clk);
		while (!lit_if.ready) @(posedge clk);
		bytes_sent++;
		parse_byte(c, last);
	endtask

	task automatic send_queue(input logic [7:0] text[$]);
		for (int i = 0; i < text.size(); i++) begin
			send_byte(text[i], i == text.size() - 1);
		end
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_byte(s[i], i == s.len() - 1);
		end
	endtask

	// Mode writes only while idle: all results in, then a wait for the two-stage
	// pipe to settle.
	task automatic write_mode(input logic signed_mode);
		lit_if.valid <= 1'b0;
		while (literal_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_if.valid         <= 1'b1;
		cfg_if.signed_result <= signed_mode;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		cfg_if.valid <= 1'b0;
		mode_signed = signed_mode;
	endtask

	// ------------------------------------------------------------------------
	// Random literal generation
	// ------------------------------------------------------------------------

	// digits needed to spell 2^64-1 in the given base
	function automatic int digits_for(input int b);
		logic [63:0] v;
		int n;
		v = '1;
		n = 0;
		while (v != 0) begin
			v = v / 64'(b);
			n++;
		end
		return n;
	endfunction

	function automatic logic [7:0] digit_char(input int v);
		if (v < 10) return CH_ZERO + 8'(v);
		return ($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(v - 10);
	endfunction

	function automatic logic [7:0] pick_fragment();
		case ($urandom_range(0, 7))
			0: return CH_MINUS;
			1: return CH_PLUS;
			2: return CH_UNDER;
			3: return CH_ZERO;
			4: return CH_X;
			5: return CH_R;
			6: return CH_NINE;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Mostly well-formed: [sign] [prefix] [zeros] digits with underscores;
	// the rest raw noise or scrambled fragments.
	task automatic send_random_literal();
		logic [7:0] text[$];
		int kind;
		int b;
		int len;
		int nz;
		int v;
		kind = $urandom_range(0, 99);
		if (kind < 10) begin
			len = $urandom_range(1, 6);
			repeat (len) text.push_back(8'($urandom_range(0, 255)));
		end else if (kind < 18) begin
			len = $urandom_range(1, 5);
			repeat (len) text.push_back(pick_fragment());
		end else begin
			case ($urandom_range(0, 2))
				1: text.push_back(CH_PLUS);
				2: text.push_back(CH_MINUS);
				default: ;
			endcase
			b = 10;
			case ($urandom_range(0, 9))
				4, 5: begin
					b = 16;
					text.push_back(CH_ZERO);
					text.push_back(CH_X);
				end
				6, 7: begin
					b = $urandom_range(0, 9);
					text.push_back(CH_ZERO + 8'(b));
					text.push_back(CH_R);
				end
				8, 9: begin
					// mostly legal two-digit bases, sometimes out of range
					b = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99)
						: $urandom_range(10, 36);
					text.push_back(CH_ZERO + 8'(b / 10));
					text.push_back(CH_ZERO + 8'(b % 10));
					text.push_back(CH_R);
				end
				default: ;
			endcase
			nz = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
			repeat (nz) text.push_back(CH_ZERO);
			// a quarter of the time aim at the 64-bit overflow edge
			if ((b >= 2) && (b <= 36) && ($urandom_range(0, 3) == 0))
				len = digits_for(b) + $urandom_range(0, 2) - 1;
			else
				len = $urandom_range(0, 8);
			for (int i = 0; i < len; i++) begin
				if ((i > 0) && ($urandom_range(0, 9) == 0)) text.push_back(CH_UNDER);
				if ($urandom_range(0, 19) == 0) v = $urandom_range(0, 35);
				else if (b < 2) v = 0;
				else v = $urandom_range(0, ((b > 36) ? 36 : b) - 1);
				text.push_back(digit_char(v));
			end
		end
		if (text.size() == 0) text.push_back(digit_char($urandom_range(0, 9)));
		send_queue(text);
	endtask

	task automatic run_random(input int n);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < n) send_random_literal();
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// unsigned mode: bases, prefixes, digit cases, failures
	task automatic test_unsigned_literals();
		write_mode(1'b0);
		send_text("0");
		send_text("18446744073709551615");   // largest unsigned
		send_text("18446744073709551616");   // one past: overflow
		send_text("-0");                     // any minus fails unsigned
		send_text("+42");
		send_text("0xffffFFFFffffFFFF");
		send_text("2r1011");
		send_text("36rZz");
		send_text("37r1");                   // base out of range
		send_text("01r1");                   // base one in two-digit form
		send_text("0r00");                   // base zero, only leading zeros
		send_text("1r0_0");                  // base one, zeros around an underscore
		send_text("0x");                     // prefix with no digit
		send_text("_1");                     // underscore before any digit
		send_text("7");                      // ends during prefix lookahead
		send_text("12");
		send_text("1_000_");
		send_text("9r9");                    // digit not below base
		send_byte(8'hFF, 1'b1);              // bytes above 127 are no digits
		send_byte(CH_ZERO + 8'd1, 1'b0);
		send_byte(8'h80, 1'b1);
	endtask

	// signed mode: the int64 range limits on both sides
	task automatic test_signed_literals();
		write_mode(1'b1);
		send_text("-9223372036854775808");
		send_text("-9223372036854775809");
		send_text("9223372036854775807");
		send_text("9223372036854775808");
		send_text("-0x1F");
		send_text("-");
		send_text("5r");
	endtask

	// byte counter saturates at the limit; one byte over fails
	task automatic test_length_limit();
		logic [7:0] text[$];
		repeat (int'(MAX_LENGTH) - 1) text.push_back(CH_ZERO);
		text.push_back(CH_NINE);
		send_queue(text);                    // exactly at the limit
		text.push_front(CH_PLUS);
		send_queue(text);                    // one over
		repeat (60) text.push_back(CH_ZERO);
		send_queue(text);                    // well past, counter stays put
	endtask

	task automatic test_random_literals();
		write_mode(1'b0);
		run_random(90);
		write_mode(1'b1);
		run_random(70);
		idle_on = 1'b0;                      // back-to-back stretch
		run_random(40);
		idle_on = 1'b1;
		write_mode(1'b0);
		run_random(50);
	endtask

	// long output hold-off while the source keeps offering words
	task automatic test_backpressure();
		idle_on = 1'b0;
		hold_request = 300;
		repeat (15) send_random_literal();
		idle_on = 1'b1;
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		lit_if.valid         = 1'b0;
		lit_if.byte_value    = '0;
		lit_if.last_byte     = 1'b0;
		cfg_if.valid         = 1'b0;
		cfg_if.signed_result = 1'b0;
		mismatches   = 0;
		bytes_sent   = 0;
		idle_on      = 1'b1;
		hold_request = 0;
		mode_signed  = 1'b0;
		reset_literal_model();

		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unsigned_literals();
		test_signed_literals();
		test_length_limit();
		test_random_literals();
		test_backpressure();

		// drain, then give the pipe time to show any stray result word
		lit_if.valid <= 1'b0;
		while (literal_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/rilp_pkg.sv
rtl/rilp_if.sv
rtl/rilp_step.sv
rtl/radix_integer_literal_parser.sv
bench/tb.sv
